// ===== hdl/pct_pkg.sv =====
package pct_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int NUM_EDGES = 4;
   localparam int NUM_TURNS = 3;
   localparam logic [1:0] VCOUNT_SAT = 2'd3;

   typedef enum logic [1:0] {
      TURN_IN   = 2'd0,
      TURN_LAST = 2'd1,
      TURN_WRAP = 2'd2
   } turn_idx_type;

   typedef struct packed {
      logic turn_in;
      logic turn_wrap;
      logic last;
   } pct_ctl_type;

   typedef struct packed {
      logic nonzero;
      logic negative;
   } pct_sign_type;

   typedef struct packed {
      logic seen_negative;
      logic seen_positive;
      logic cw;
      logic decided;
   } pct_flags_type;

   function automatic pct_flags_type apply_turn(pct_flags_type f, pct_sign_type s);
      pct_flags_type r;
      r = f;
      if (!f.decided) begin
         if (s.nonzero && s.negative) begin
            r.seen_negative = 1'b1;
            r.cw = 1'b1;
         end else if (s.nonzero) begin
            r.seen_positive = 1'b1;
            r.cw = 1'b0;
         end
         r.decided = r.seen_negative && r.seen_positive;
      end
      return r;
   endfunction

endpackage

// ===== hdl/polygon_convexity_test.sv =====
// A result word is presented after the last vertex word passes the edge-difference, multiplier and sign registers.
// Throughput: one vertex word per cycle, through three register stages (edge
// differences, cross-product multipliers, sign tracking and result register).
// The input stalls only while a result word waits on a low rsp_ready.
// Reset is synchronous and active high; it clears all stages and starts a new polygon.
module polygon_convexity_test #(
   parameter int COORD_WIDTH = pct_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_y,
   input  logic                          req_last_vertex,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_is_convex,
   output logic                          rsp_clockwise,
   output logic                          rsp_turn_seen
);
   import pct_pkg::*;

   localparam int PW = 2 * COORD_WIDTH + 2;

   logic                         s1_valid, s1_ready;
   pct_ctl_type                  s1_ctl;
   logic signed [COORD_WIDTH:0]  s1_dx [NUM_EDGES];
   logic signed [COORD_WIDTH:0]  s1_dy [NUM_EDGES];
   logic                         s2_valid, s2_ready;
   pct_ctl_type                  s2_ctl;
   logic signed [PW-1:0]         s2_prod_p [NUM_TURNS];
   logic signed [PW-1:0]         s2_prod_n [NUM_TURNS];

   pct_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_vertex_x    (req_vertex_x),
      .req_vertex_y    (req_vertex_y),
      .req_last_vertex (req_last_vertex),
      .dn_ready        (s1_ready),
      .dn_valid        (s1_valid),
      .dn_ctl          (s1_ctl),
      .dn_dx           (s1_dx),
      .dn_dy           (s1_dy)
   );

   pct_mult #(.COORD_WIDTH(COORD_WIDTH)) u_mult (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (s1_valid),
      .up_ready  (s1_ready),
      .up_ctl    (s1_ctl),
      .up_dx     (s1_dx),
      .up_dy     (s1_dy),
      .dn_ready  (s2_ready),
      .dn_valid  (s2_valid),
      .dn_ctl    (s2_ctl),
      .dn_prod_p (s2_prod_p),
      .dn_prod_n (s2_prod_n)
   );

   pct_sign #(.COORD_WIDTH(COORD_WIDTH)) u_sign (
      .clock         (clock),
      .reset         (reset),
      .up_valid      (s2_valid),
      .up_ready      (s2_ready),
      .up_ctl        (s2_ctl),
      .up_prod_p     (s2_prod_p),
      .up_prod_n     (s2_prod_n),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_convex (rsp_is_convex),
      .rsp_clockwise (rsp_clockwise),
      .rsp_turn_seen (rsp_turn_seen)
   );

endmodule

// ===== hdl/pct_front.sv =====
module pct_front #(
   parameter int COORD_WIDTH = pct_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_x,
   input  logic signed [COORD_WIDTH-1:0] req_vertex_y,
   input  logic                          req_last_vertex,
   input  logic                          dn_ready,
   output logic                          dn_valid,
   output pct_pkg::pct_ctl_type          dn_ctl,
   output logic signed [COORD_WIDTH:0]   dn_dx [pct_pkg::NUM_EDGES],
   output logic signed [COORD_WIDTH:0]   dn_dy [pct_pkg::NUM_EDGES]
);
   import pct_pkg::*;

   localparam int DW = COORD_WIDTH + 1;

   logic signed [COORD_WIDTH-1:0] first_x_ff, first_y_ff, second_x_ff, second_y_ff;
   logic signed [COORD_WIDTH-1:0] older_x_ff, older_y_ff, prior_x_ff, prior_y_ff;
   logic [1:0]                    vcount_ff;
   logic                          valid_ff;
   pct_ctl_type                   ctl_ff, ctl_in;
   logic signed [DW-1:0]          dx_ff [NUM_EDGES];
   logic signed [DW-1:0]          dy_ff [NUM_EDGES];
   logic signed [DW-1:0]          dx_in [NUM_EDGES];
   logic signed [DW-1:0]          dy_in [NUM_EDGES];
   logic                          accept;
   logic                          have_two;

   assign req_ready = !valid_ff || dn_ready;
   assign accept    = req_valid && req_ready;
   assign have_two  = vcount_ff[1];

   // Edge 0 enters the previous vertex, edge 1 enters the new vertex, edge 2 closes
   // back to vertex 0, and edge 3 leaves vertex 0.
   always_comb begin
      dx_in[0] = {prior_x_ff[COORD_WIDTH-1], prior_x_ff} - {older_x_ff[COORD_WIDTH-1], older_x_ff};
      dy_in[0] = {prior_y_ff[COORD_WIDTH-1], prior_y_ff} - {older_y_ff[COORD_WIDTH-1], older_y_ff};
      dx_in[1] = {req_vertex_x[COORD_WIDTH-1], req_vertex_x} - {prior_x_ff[COORD_WIDTH-1], prior_x_ff};
      dy_in[1] = {req_vertex_y[COORD_WIDTH-1], req_vertex_y} - {prior_y_ff[COORD_WIDTH-1], prior_y_ff};
      dx_in[2] = {first_x_ff[COORD_WIDTH-1], first_x_ff} - {req_vertex_x[COORD_WIDTH-1], req_vertex_x};
      dy_in[2] = {first_y_ff[COORD_WIDTH-1], first_y_ff} - {req_vertex_y[COORD_WIDTH-1], req_vertex_y};
      dx_in[3] = {second_x_ff[COORD_WIDTH-1], second_x_ff} - {first_x_ff[COORD_WIDTH-1], first_x_ff};
      dy_in[3] = {second_y_ff[COORD_WIDTH-1], second_y_ff} - {first_y_ff[COORD_WIDTH-1], first_y_ff};
      ctl_in.turn_in   = have_two;
      ctl_in.turn_wrap = have_two && req_last_vertex;
      ctl_in.last      = req_last_vertex;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         vcount_ff   <= 2'd0;
         first_x_ff  <= '0;
         first_y_ff  <= '0;
         second_x_ff <= '0;
         second_y_ff <= '0;
         older_x_ff  <= '0;
         older_y_ff  <= '0;
         prior_x_ff  <= '0;
         prior_y_ff  <= '0;
      end else begin
         if (accept) begin
            valid_ff <= 1'b1;
         end else if (dn_ready) begin
            valid_ff <= 1'b0;
         end
         if (accept) begin
            if (req_last_vertex) begin
               vcount_ff <= 2'd0;
            end else begin
               if (vcount_ff == 2'd0) begin
                  first_x_ff <= req_vertex_x;
                  first_y_ff <= req_vertex_y;
               end else if (vcount_ff == 2'd1) begin
                  second_x_ff <= req_vertex_x;
                  second_y_ff <= req_vertex_y;
               end
               older_x_ff <= prior_x_ff;
               older_y_ff <= prior_y_ff;
               prior_x_ff <= req_vertex_x;
               prior_y_ff <= req_vertex_y;
               if (vcount_ff != VCOUNT_SAT) begin
                  vcount_ff <= vcount_ff + 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctl_ff <= ctl_in;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_ctl   = ctl_ff;
   assign dn_dx    = dx_ff;
   assign dn_dy    = dy_ff;

endmodule

// ===== hdl/pct_mult.sv =====
module pct_mult #(
   parameter int COORD_WIDTH = pct_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  pct_pkg::pct_ctl_type              up_ctl,
   input  logic signed [COORD_WIDTH:0]       up_dx [pct_pkg::NUM_EDGES],
   input  logic signed [COORD_WIDTH:0]       up_dy [pct_pkg::NUM_EDGES],
   input  logic                              dn_ready,
   output logic                              dn_valid,
   output pct_pkg::pct_ctl_type              dn_ctl,
   output logic signed [2*COORD_WIDTH+1:0]   dn_prod_p [pct_pkg::NUM_TURNS],
   output logic signed [2*COORD_WIDTH+1:0]   dn_prod_n [pct_pkg::NUM_TURNS]
);
   import pct_pkg::*;

   localparam int PW = 2 * COORD_WIDTH + 2;

   logic                 valid_ff;
   pct_ctl_type          ctl_ff;
   logic signed [PW-1:0] prod_p_ff [NUM_TURNS];
   logic signed [PW-1:0] prod_n_ff [NUM_TURNS];
   logic signed [PW-1:0] prod_p_in [NUM_TURNS];
   logic signed [PW-1:0] prod_n_in [NUM_TURNS];
   logic                 load;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;

   // The turn at a vertex uses the edge into it and the edge out of it.
   always_comb begin
      for (int t = 0; t < NUM_TURNS; t++) begin
         prod_p_in[t] = PW'(up_dx[t]) * PW'(up_dy[t+1]);
         prod_n_in[t] = PW'(up_dy[t]) * PW'(up_dx[t+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (dn_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctl_ff    <= up_ctl;
         prod_p_ff <= prod_p_in;
         prod_n_ff <= prod_n_in;
      end
   end

   assign dn_valid  = valid_ff;
   assign dn_ctl    = ctl_ff;
   assign dn_prod_p = prod_p_ff;
   assign dn_prod_n = prod_n_ff;

endmodule

// ===== hdl/pct_sign.sv =====
module pct_sign #(
   parameter int COORD_WIDTH = pct_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  pct_pkg::pct_ctl_type              up_ctl,
   input  logic signed [2*COORD_WIDTH+1:0]   up_prod_p [pct_pkg::NUM_TURNS],
   input  logic signed [2*COORD_WIDTH+1:0]   up_prod_n [pct_pkg::NUM_TURNS],
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_is_convex,
   output logic                              rsp_clockwise,
   output logic                              rsp_turn_seen
);
   import pct_pkg::*;

   localparam int PW = 2 * COORD_WIDTH + 2;
   localparam int SW = PW + 1;

   pct_flags_type        flags_ff, flags_in;
   logic                 rsp_valid_ff;
   logic                 is_convex_ff, clockwise_ff, turn_seen_ff;
   logic signed [SW-1:0] cross_diff [NUM_TURNS];
   pct_sign_type         sgn [NUM_TURNS];
   logic                 out_free;
   logic                 take;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign take     = up_valid && (out_free || !up_ctl.last);
   assign up_ready = !up_valid || take;

   always_comb begin
      for (int t = 0; t < NUM_TURNS; t++) begin
         cross_diff[t] = {up_prod_p[t][PW-1], up_prod_p[t]} - {up_prod_n[t][PW-1], up_prod_n[t]};
         sgn[t].nonzero  = |cross_diff[t];
         sgn[t].negative = cross_diff[t][SW-1];
      end
      flags_in = flags_ff;
      if (up_ctl.turn_in) begin
         flags_in = apply_turn(flags_in, sgn[TURN_IN]);
      end
      if (up_ctl.turn_wrap) begin
         flags_in = apply_turn(flags_in, sgn[TURN_LAST]);
         flags_in = apply_turn(flags_in, sgn[TURN_WRAP]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            flags_ff <= up_ctl.last ? '0 : flags_in;
         end
         if (take && up_ctl.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && up_ctl.last) begin
         is_convex_ff <= !(flags_in.seen_negative && flags_in.seen_positive);
         clockwise_ff <= flags_in.cw;
         turn_seen_ff <= flags_in.seen_negative || flags_in.seen_positive;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_convex = is_convex_ff;
   assign rsp_clockwise = clockwise_ff;
   assign rsp_turn_seen = turn_seen_ff;

endmodule

// ===== hdl/pct_checker.sv =====
module pct_checker #(
   parameter int COORD_WIDTH = pct_pkg::COORD_WIDTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic signed [COORD_WIDTH-1:0] req_vertex_x,
   input logic signed [COORD_WIDTH-1:0] req_vertex_y,
   input logic                          req_last_vertex,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_is_convex,
   input logic                          rsp_clockwise,
   input logic                          rsp_turn_seen
);

   // A waiting vertex word is held until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_vertex_x)
         && $stable(req_vertex_y) && $stable(req_last_vertex))
      else $error("vertex word changed while waiting");

   // A stalled result word keeps its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_convex)
         && $stable(rsp_clockwise) && $stable(rsp_turn_seen))
      else $error("result word changed while stalled");

   // A polygon can only be reported as not convex if it had a nonzero turn.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_convex |-> rsp_turn_seen)
      else $error("non-convex result without any turn");

   // The input side stalls only behind a waiting result word.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a blocked result");

   // No result word comes out of reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

endmodule

bind polygon_convexity_test pct_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pct_checker (.*);
